// ===== hdl/polygon_area_mass_unit_macros.svh =====
// ----------------------------------------------------------------------------
// polygon_area_mass_unit assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_MASS_UNIT_MACROS_SVH
`define POLYGON_AREA_MASS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of i_clk, ignored while reset is asserted
`define PAM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("polygon_area_mass_unit: assertion failed");
// Checked on every rising edge of i_clk, reset included
`define PAM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("polygon_area_mass_unit: assertion failed");
`else
`define PAM_ASSERT(lbl, prop)
`define PAM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/pam_pkg.sv =====
// ----------------------------------------------------------------------------
// pam_pkg
// Types and constants shared by the polygon area and mass unit.
// ----------------------------------------------------------------------------
package pam_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DENSITY = 1'b0;

    localparam logic [15:0] DENSITY_RST = 16'd256;

    localparam logic signed [40:0] SUM_MAX  = {1'b0, {40{1'b1}}};
    localparam logic signed [40:0] SUM_MIN  = {1'b1, {40{1'b0}}};
    localparam logic [39:0]        AREA_MAX = {40{1'b1}};
    localparam logic [54:0]        MASS_MAX = {55{1'b1}};

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic [39:0] twice_area;
        logic [54:0] mass;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul_en;
        logic mul_cls;
        logic acc_en;
        logic abs_en;
        logic mass_en;
        logic load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/polygon_area_mass_unit.sv =====
// ----------------------------------------------------------------------------
// polygon_area_mass_unit
// Streaming shoelace polygon area with mass from a Q8.8 density register.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_ready o_out_data (t_out_item)
//   config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// A vertex is stepped through accept, product pair and accumulate; the closing
// vertex then walks the single product pair again, the accumulator, the magnitude,
// the 40x16 mass multiplier and the result load one step at a time, as set by the sequencer.
// The result sits in an output register, so the next vertex is taken while it
// waits; the closing vertex stalls only if the previous result is still held.
// Synchronous active-low reset; density resets to 1.0.
// ----------------------------------------------------------------------------
`include "polygon_area_mass_unit_macros.svh"

module polygon_area_mass_unit
    import pam_pkg::*;
#(
    parameter int MAX_VERTICES = 256
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [15:0] r_density;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= DENSITY_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DENSITY)) begin
            r_density <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DENSITY) ? PDATA_W'(r_density) : '0;

    pam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pam_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_density   (r_density),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // one datapath step per cycle; mul_cls only rides along with mul_en
    `PAM_ASSERT(a_one_step, $countones(w_cmd) <= (w_cmd.mul_cls ? 2 : 1))
    // a vertex transfer always takes the unit out of the ready state
    `PAM_ASSERT(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // a result is never written over one that has not been taken
    `PAM_ASSERT(a_no_overwrite, w_cmd.load |-> (!o_out_valid || i_out_ready))
    `PAM_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

// ===== hdl/pam_ctrl.sv =====
// ----------------------------------------------------------------------------
// pam_ctrl
// Sequencer: steps the datapath through the cross-product terms of a vertex
// and, on the closing vertex, through absolute value, mass and result load.
// ----------------------------------------------------------------------------
module pam_ctrl
    import pam_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NMUL = 3'd1;
    localparam logic [2:0] S_NACC = 3'd2;
    localparam logic [2:0] S_CMUL = 3'd3;
    localparam logic [2:0] S_CACC = 3'd4;
    localparam logic [2:0] S_ABS  = 3'd5;
    localparam logic [2:0] S_MMUL = 3'd6;
    localparam logic [2:0] S_LOAD = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_NMUL;
                end
            end
            S_NMUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_NACC;
            end
            S_NACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = i_sts.last ? S_CMUL : S_IDLE;
            end
            S_CMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_cls = 1'b1;
                n_state       = S_CACC;
            end
            S_CACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_ABS;
            end
            S_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.mass_en = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/pam_dp.sv =====
// ----------------------------------------------------------------------------
// pam_dp
// Datapath: vertex registers, product pair, saturating shoelace accumulator,
// magnitude, mass multiplier and the output register.
// ----------------------------------------------------------------------------
module pam_dp
    import pam_pkg::*;
#(
    parameter int MAX_VERTICES = 256
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_data,
    input  logic [15:0] i_density,
    input  logic      i_out_ready,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

    logic signed [15:0] r_first_x, r_first_y;
    logic signed [15:0] r_prev_x, r_prev_y;
    logic signed [15:0] r_cur_x, r_cur_y;
    logic signed [31:0] r_p1, r_p2;
    logic signed [40:0] r_sum;
    logic               r_have_first;
    logic [CW-1:0]      r_count;
    logic               r_last;
    logic [39:0]        r_mag;
    logic [55:0]        r_prod;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      n_count;
    logic signed [15:0] w_ax, w_ay, w_bx, w_by;
    logic signed [31:0] w_p1, w_p2;
    logic signed [41:0] w_sum_ext;
    logic signed [40:0] w_sum_sat;
    logic [40:0]        w_abs;

    assign n_count = r_have_first ? (r_count + CW'(1)) : CW'(1);

    // term = a.x * b.y - b.x * a.y; closing term runs current -> first vertex
    assign w_ax = i_cmd.mul_cls ? r_cur_x   : r_prev_x;
    assign w_ay = i_cmd.mul_cls ? r_cur_y   : r_prev_y;
    assign w_bx = i_cmd.mul_cls ? r_first_x : r_cur_x;
    assign w_by = i_cmd.mul_cls ? r_first_y : r_cur_y;
    assign w_p1 = w_ax * w_by;
    assign w_p2 = w_bx * w_ay;

    assign w_sum_ext = 42'(r_sum) + 42'(r_p1) - 42'(r_p2);
    assign w_sum_sat = (w_sum_ext[41] != w_sum_ext[40])
                     ? (w_sum_ext[41] ? SUM_MIN : SUM_MAX)
                     : w_sum_ext[40:0];

    assign w_abs = r_sum[40] ? 41'(-r_sum) : 41'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_cur_x <= i_in_data.vert_x;
                r_cur_y <= i_in_data.vert_y;
                r_count <= n_count;
                r_last  <= i_in_data.last_vertex || (n_count >= MaxCnt);
                if (!r_have_first) begin
                    // first vertex: prev = cur makes the first term zero
                    r_first_x    <= i_in_data.vert_x;
                    r_first_y    <= i_in_data.vert_y;
                    r_prev_x     <= i_in_data.vert_x;
                    r_prev_y     <= i_in_data.vert_y;
                    r_sum        <= '0;
                    r_have_first <= 1'b1;
                end
            end
            if (i_cmd.mul_en) begin
                r_p1 <= w_p1;
                r_p2 <= w_p2;
            end
            if (i_cmd.acc_en) begin
                r_sum    <= w_sum_sat;
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
            end
            if (i_cmd.abs_en) begin
                r_mag <= w_abs[40] ? AREA_MAX : w_abs[39:0];
            end
            if (i_cmd.mass_en) begin
                r_prod <= 56'(r_mag) * 56'(i_density);
            end
            if (i_cmd.load) begin
                r_out.twice_area <= r_mag;
                r_out.mass       <= r_prod[55] ? MASS_MAX : r_prod[54:0];
                r_out_valid      <= 1'b1;
                r_have_first     <= 1'b0;
                r_count          <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== tb/polygon_area_mass_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_area_mass_unit_test
// Streams polygons into the unit and checks each closed polygon's twice-area
// and mass against an in-bench shoelace predictor. A directed set of shapes
// comes first, then phases of random polygons and broken flag sequences under
// several density settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module polygon_area_mass_unit_test;
    import pam_pkg::*;

    localparam int VERT_LIMIT = 256;
    localparam int HOLD_LEN   = 400;     // long receiver stall
    localparam int SETTLE     = 12;      // margin for the closing vertex to finish
    localparam int IDLE_LIMIT = 5000;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    t_in_item           in_data    = '0;
    logic               out_ready  = 1'b0;
    logic               apb_sel    = 1'b0;
    logic               apb_enable = 1'b0;
    logic               apb_write  = 1'b0;
    logic [PADDR_W-1:0] apb_addr   = '0;
    logic [PDATA_W-1:0] apb_wdata  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic [PDATA_W-1:0] apb_rdata;
    logic               apb_ready;

    // shoelace predictor state
    logic signed [15:0] first_x, first_y, prev_x, prev_y;
    logic signed [40:0] cross_sum;
    logic               have_first;
    logic [16:0]        vert_count;
    logic [15:0]        density_q88 = DENSITY_RST;

    t_in_item  vertex_queue[$];
    t_out_item pending_areas[$];

    int  error_count    = 0;
    int  vertices_taken = 0;
    int  results_seen   = 0;
    int  forced_closes  = 0;
    int  density_writes = 0;
    int  idle_cycles    = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  idle_on        = 1'b1;
    bit  hold_req       = 1'b0;
    bit  hold_ack       = 1'b0;

    polygon_area_mass_unit #(.MAX_VERTICES(VERT_LIMIT)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (apb_sel),
        .penable     (apb_enable),
        .pwrite      (apb_write),
        .paddr       (apb_addr),
        .pwdata      (apb_wdata),
        .prdata      (apb_rdata),
        .pready      (apb_ready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 70) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cross(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] bx, input logic signed [15:0] by);
        logic signed [32:0] term;
        logic signed [41:0] sum;
        term = ax * by - bx * ay;
        sum  = cross_sum + term;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
        end
        if (sum < SUM_MIN) begin
            sum = SUM_MIN;
        end
        cross_sum = sum[40:0];
    endtask

    task automatic shoelace_step(input t_in_item v);
        logic               close;
        logic signed [41:0] wide;
        logic [41:0]        mag;
        logic [56:0]        weighted;
        t_out_item          res;
        close = v.last_vertex;
        if (!have_first) begin
            first_x    = v.vert_x;
            first_y    = v.vert_y;
            cross_sum  = '0;
            have_first = 1'b1;
            vert_count = 17'd1;
        end else begin
            add_cross(prev_x, prev_y, v.vert_x, v.vert_y);
            vert_count = vert_count + 17'd1;
        end
        prev_x = v.vert_x;
        prev_y = v.vert_y;
        if (vert_count >= VERT_LIMIT) begin
            if (!close) begin
                forced_closes++;
            end
            close = 1'b1;
        end
        if (close) begin
            add_cross(prev_x, prev_y, first_x, first_y);
            wide = cross_sum;
            mag  = (wide < 0) ? -wide : wide;
            if (mag > AREA_MAX) begin
                mag = AREA_MAX;
            end
            weighted = mag[39:0] * density_q88;
            if (weighted > MASS_MAX) begin
                weighted = MASS_MAX;
            end
            res.twice_area = mag[39:0];
            res.mass       = weighted[54:0];
            pending_areas.push_back(res);
            have_first = 1'b0;
            cross_sum  = '0;
            vert_count = '0;
        end
    endtask

    // vertex sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            first_x    = '0;
            first_y    = '0;
            prev_x     = '0;
            prev_y     = '0;
            cross_sum  = '0;
            have_first = 1'b0;
            vert_count = '0;
            send_gap   = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                shoelace_step(in_data);
                vertices_taken++;
            end
            if (in_valid && !o_in_ready) begin
                // hold until the transfer happens
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (vertex_queue.size() != 0) begin
                in_data  <= vertex_queue.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  <= hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (pending_areas.size() == 0) begin
                $error("result with nothing expected: twice_area %0d mass %0d",
                       o_out_data.twice_area, o_out_data.mass);
                error_count++;
            end else begin
                want = pending_areas.pop_front();
                if (o_out_data.twice_area !== want.twice_area) begin
                    $error("twice_area mismatch: expected %0d, got %0d",
                           want.twice_area, o_out_data.twice_area);
                    error_count++;
                end
                if (o_out_data.mass !== want.mass) begin
                    $error("mass mismatch: expected %0d, got %0d",
                           want.mass, o_out_data.mass);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (apb_sel && apb_enable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic last);
        t_in_item v;
        v.vert_x      = x;
        v.vert_y      = y;
        v.last_vertex = last;
        vertex_queue.push_back(v);
    endtask

    function automatic logic signed [15:0] rand_coord(input int span);
        case (span)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'sd32;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
    endfunction

    // n vertices, flag on the final one only
    task automatic queue_polygon(input int n, input int span);
        for (int k = 0; k < n; k++) begin
            queue_vertex(rand_coord(span), rand_coord(span), k == n - 1);
        end
    endtask

    task automatic queue_random(input int budget);
        int queued;
        int r;
        int n;
        queued = 0;
        while (queued < budget) begin
            r = $urandom_range(0, 99);
            if (r < 1) begin
                n = $urandom_range(200, 280);     // may cross the vertex limit
                queue_polygon(n, $urandom_range(0, 3));
            end else if (r < 85) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
                queue_polygon(n, $urandom_range(0, 3));
            end else begin
                // broken sequence: random flags
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    queue_vertex(rand_coord(0), rand_coord(0), $urandom_range(0, 1));
                end
            end
            queued += n;
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (vertex_queue.size() != 0 || in_valid || pending_areas.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_density(input logic [15:0] value);
        wait_drained();
        @(posedge i_clk);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {REG_DENSITY, 2'b00};
        apb_wdata  <= {16'd0, value};
        @(posedge i_clk);
        apb_enable <= 1'b1;
        @(posedge i_clk);
        density_q88 = value;
        density_writes++;
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed shapes at reset density
        queue_vertex(16'sh7FFF, 16'sh7FFF, 1'b1);                 // lone vertex
        queue_vertex(16'sh8000, 16'sh8000, 1'b0);                 // two vertices
        queue_vertex(16'sh7FFF, 16'sh7FFF, 1'b1);
        queue_vertex(16'sd0, 16'sd0, 1'b0);                       // 16 by 16 square
        queue_vertex(16'sd16, 16'sd0, 1'b0);
        queue_vertex(16'sd16, 16'sd16, 1'b0);
        queue_vertex(16'sd0, 16'sd16, 1'b1);
        queue_vertex(16'sh8000, 16'sh8000, 1'b0);                 // full-range square
        queue_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        queue_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        queue_vertex(16'sh8000, 16'sh7FFF, 1'b1);
        queue_vertex(16'sh8000, 16'sh8000, 1'b0);                 // same, clockwise
        queue_vertex(16'sh8000, 16'sh7FFF, 1'b0);
        queue_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        queue_vertex(16'sh7FFF, 16'sh8000, 1'b1);
        queue_vertex(16'sh7FFF, 16'sh8000, 1'b0);                 // mixed extremes
        queue_vertex(16'sh8000, 16'sd0, 1'b0);
        queue_vertex(16'sd0, 16'sh7FFF, 1'b1);
        queue_vertex(-16'sd5, -16'sd5, 1'b0);                     // collinear
        queue_vertex(16'sd3, 16'sd3, 1'b0);
        queue_vertex(16'sd9, 16'sd9, 1'b1);

        // largest density: full-range square again and a polygon hitting the limit
        write_density(16'hFFFF);
        queue_vertex(16'sh8000, 16'sh8000, 1'b0);
        queue_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        queue_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        queue_vertex(16'sh8000, 16'sh7FFF, 1'b1);
        for (int k = 0; k < VERT_LIMIT; k++) begin
            queue_vertex(rand_coord(2), rand_coord(2), 1'b0);
        end
        queue_polygon(4, 1);

        write_density(16'h0000);
        queue_random(60);

        // long receiver stall while vertices keep coming
        write_density(16'($urandom));
        hold_req <= ~hold_req;
        queue_random(100);

        // back-to-back traffic
        write_density(16'h0001);
        idle_on = 1'b0;
        queue_random(60);

        write_density(16'($urandom));
        idle_on = 1'b1;
        queue_random(100);

        wait_drained();
        if (pending_areas.size() != 0) begin
            error_count++;
        end
        $display("Covered %0d vertices, %0d polygon results (%0d closed at the vertex limit),",
                 vertices_taken, results_seen, forced_closes);
        $display("over %0d density writes including 0 and 65535, with idling and a long stall.",
                 density_writes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pam_pkg.sv
hdl/pam_ctrl.sv
hdl/pam_dp.sv
hdl/polygon_area_mass_unit.sv
tb/polygon_area_mass_unit_test.sv
